>>> src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define CSPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check of the consequent in the cycle after the trigger.
`define CSPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/cspu_pkg.sv
// ----------------------------------------------------------------------------
// cspu_pkg
// Widths, register indexes, reset values and feature codes of the cone support point unit.
// ----------------------------------------------------------------------------
package cspu_pkg;

  localparam int DIR_BITS     = 16;
  localparam int LEN_BITS     = 16;
  localparam int OUT_BITS     = LEN_BITS + 1;
  localparam int CFG_IDX_BITS = 2;

  localparam int SQ_BITS  = 2 * DIR_BITS;
  localparam int S2_BITS  = SQ_BITS + 1;
  localparam int N_BITS   = LEN_BITS + DIR_BITS + 1;
  localparam int NSQ_BITS = 2 * N_BITS;
  localparam int RR_BITS  = 2 * LEN_BITS;
  localparam int RHS_BITS = RR_BITS + S2_BITS;
  localparam int RES_BITS = NSQ_BITS + 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS      = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [LEN_BITS-1:0] RADIUS_RESET      = LEN_BITS'(256);
  localparam logic [LEN_BITS-1:0] HALF_HEIGHT_RESET = LEN_BITS'(256);

  typedef enum logic [1:0] {
    FEAT_APEX   = 2'd0,
    FEAT_RIM    = 2'd1,
    FEAT_CENTRE = 2'd2
  } feature_e;

endpackage

>>> src/cone_support_point_unit.sv
// Throughput: one direction per cycle while the output is not stalled; each rim
// coordinate bit is resolved in a pipeline stage of its own (LEN_BITS stages),
// so the stage count sets latency.
// Stall on the output freezes the whole pipeline; nothing is dropped.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets radius and
// half height to 1.0 (256 in Q8.8).
// ----------------------------------------------------------------------------
// cone_support_point_unit
// Support mapping of a y-axis cone: apex test, then rim point by an
// add-and-shift square root/divide pipeline, or the base centre when x and z are zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cone_support_point_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cspu_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [cspu_pkg::LEN_BITS-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [cspu_pkg::DIR_BITS-1:0] direction_x_i,
  input  logic signed [cspu_pkg::DIR_BITS-1:0] direction_y_i,
  input  logic signed [cspu_pkg::DIR_BITS-1:0] direction_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [cspu_pkg::OUT_BITS-1:0] point_x_o,
  output logic signed [cspu_pkg::OUT_BITS-1:0] point_y_o,
  output logic signed [cspu_pkg::OUT_BITS-1:0] point_z_o,
  output logic [1:0]                         feature_o
);

  localparam int L   = cspu_pkg::LEN_BITS;
  localparam int D   = cspu_pkg::DIR_BITS;
  localparam int RES = cspu_pkg::RES_BITS;

  logic en;
  logic [L-1:0] radius_q, half_height_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= cspu_pkg::RADIUS_RESET;
      half_height_q <= cspu_pkg::HALF_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == cspu_pkg::REG_RADIUS) radius_q <= cfg_data_i;
      if (cfg_index_i == cspu_pkg::REG_HALF_HEIGHT) half_height_q <= cfg_data_i;
    end
  end

  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage A: magnitudes and signs
  logic a_valid_q;
  logic [D-1:0] a_ax_q, a_ay_q, a_az_q;
  logic a_sx_q, a_sz_q, a_ypos_q;
  logic [L-1:0] a_r_q, a_h_q;
  logic [D-1:0] ax_d, ay_d, az_d;

  always_comb begin
    ax_d = direction_x_i[D-1] ? D'(-direction_x_i) : direction_x_i;
    ay_d = direction_y_i[D-1] ? D'(-direction_y_i) : direction_y_i;
    az_d = direction_z_i[D-1] ? D'(-direction_z_i) : direction_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_valid_q <= 1'b0;
    else if (en) a_valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ax_q   <= ax_d;
      a_ay_q   <= ay_d;
      a_az_q   <= az_d;
      a_sx_q   <= direction_x_i[D-1];
      a_sz_q   <= direction_z_i[D-1];
      a_ypos_q <= !direction_y_i[D-1] && (direction_y_i != '0);
      a_r_q    <= radius_q;
      a_h_q    <= half_height_q;
    end
  end

  // Stage B: first products
  logic b_valid_q;
  logic [cspu_pkg::SQ_BITS-1:0] b_sqx_q, b_sqz_q;
  logic [cspu_pkg::N_BITS-1:0]  b_t_q, b_nx_q, b_nz_q;
  logic [cspu_pkg::RR_BITS-1:0] b_rr_q;
  logic b_sx_q, b_sz_q, b_ypos_q;
  logic [L-1:0] b_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_valid_q <= 1'b0;
    else if (en) b_valid_q <= a_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_sqx_q  <= a_ax_q * a_ax_q;
      b_sqz_q  <= a_az_q * a_az_q;
      b_t_q    <= {(cspu_pkg::N_BITS-1)'(a_h_q * a_ay_q), 1'b0};
      b_nx_q   <= {(cspu_pkg::N_BITS-1)'(a_r_q * a_ax_q), 1'b0};
      b_nz_q   <= {(cspu_pkg::N_BITS-1)'(a_r_q * a_az_q), 1'b0};
      b_rr_q   <= a_r_q * a_r_q;
      b_sx_q   <= a_sx_q;
      b_sz_q   <= a_sz_q;
      b_ypos_q <= a_ypos_q;
      b_h_q    <= a_h_q;
    end
  end

  // Stage C: squares of the scaled terms, radial norm
  logic c_valid_q;
  logic [cspu_pkg::S2_BITS-1:0]  c_s2_q;
  logic [cspu_pkg::NSQ_BITS-1:0] c_lhs_q, c_nsx_q, c_nsz_q;
  logic [cspu_pkg::RR_BITS-1:0]  c_rr_q;
  logic c_sx_q, c_sz_q, c_ypos_q;
  logic [L-1:0] c_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_valid_q <= 1'b0;
    else if (en) c_valid_q <= b_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_s2_q   <= cspu_pkg::S2_BITS'(b_sqx_q) + cspu_pkg::S2_BITS'(b_sqz_q);
      c_lhs_q  <= b_t_q * b_t_q;
      c_nsx_q  <= b_nx_q * b_nx_q;
      c_nsz_q  <= b_nz_q * b_nz_q;
      c_rr_q   <= b_rr_q;
      c_sx_q   <= b_sx_q;
      c_sz_q   <= b_sz_q;
      c_ypos_q <= b_ypos_q;
      c_h_q    <= b_h_q;
    end
  end

  // Stage D: right side of the apex test
  logic d_valid_q;
  logic [cspu_pkg::S2_BITS-1:0]  d_s2_q;
  logic [cspu_pkg::NSQ_BITS-1:0] d_lhs_q, d_nsx_q, d_nsz_q;
  logic [cspu_pkg::RHS_BITS-1:0] d_rhs_q;
  logic d_sx_q, d_sz_q, d_ypos_q;
  logic [L-1:0] d_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_valid_q <= 1'b0;
    else if (en) d_valid_q <= c_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_s2_q   <= c_s2_q;
      d_lhs_q  <= c_lhs_q;
      d_nsx_q  <= c_nsx_q;
      d_nsz_q  <= c_nsz_q;
      d_rhs_q  <= c_rr_q * c_s2_q;
      d_sx_q   <= c_sx_q;
      d_sz_q   <= c_sz_q;
      d_ypos_q <= c_ypos_q;
      d_h_q    <= c_h_q;
    end
  end

  // Stage E onward: feature decision, then one rim bit per stage.
  // Residual holds N^2 - (2q-1)^2*s2, and p holds (2q-1)*s2.
  logic                        it_valid_q [0:L];
  logic signed [RES-1:0]       it_rx_q    [0:L];
  logic signed [RES-1:0]       it_rz_q    [0:L];
  logic signed [RES-1:0]       it_px_q    [0:L];
  logic signed [RES-1:0]       it_pz_q    [0:L];
  logic [L-1:0]                it_qx_q    [0:L];
  logic [L-1:0]                it_qz_q    [0:L];
  logic [cspu_pkg::S2_BITS-1:0] it_s2_q   [0:L];
  logic                        it_sx_q    [0:L];
  logic                        it_sz_q    [0:L];
  logic [L-1:0]                it_h_q     [0:L];
  cspu_pkg::feature_e          it_feat_q  [0:L];

  cspu_pkg::feature_e    feat_d;
  logic signed [RES-1:0] s2_ext;

  always_comb begin
    s2_ext = RES'(d_s2_q);
    if (d_ypos_q && (cspu_pkg::RHS_BITS'(d_lhs_q) > d_rhs_q)) feat_d = cspu_pkg::FEAT_APEX;
    else if (d_s2_q != '0) feat_d = cspu_pkg::FEAT_RIM;
    else feat_d = cspu_pkg::FEAT_CENTRE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) it_valid_q[0] <= 1'b0;
    else if (en) it_valid_q[0] <= d_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it_rx_q[0]   <= RES'(d_nsx_q) - s2_ext;
      it_rz_q[0]   <= RES'(d_nsz_q) - s2_ext;
      it_px_q[0]   <= -s2_ext;
      it_pz_q[0]   <= -s2_ext;
      it_qx_q[0]   <= '0;
      it_qz_q[0]   <= '0;
      it_s2_q[0]   <= d_s2_q;
      it_sx_q[0]   <= d_sx_q;
      it_sz_q[0]   <= d_sz_q;
      it_h_q[0]    <= d_h_q;
      it_feat_q[0] <= feat_d;
    end
  end

  for (genvar k = 0; k < L; k++) begin : g_bit
    localparam int B = L - 1 - k;
    logic signed [RES-1:0] s2_w, sq_term, tx, tz;
    logic acc_x, acc_z;

    always_comb begin
      s2_w    = RES'(it_s2_q[k]);
      sq_term = s2_w <<< (2 * B + 2);
      tx      = it_rx_q[k] - (it_px_q[k] <<< (B + 2)) - sq_term;
      tz      = it_rz_q[k] - (it_pz_q[k] <<< (B + 2)) - sq_term;
      acc_x   = !tx[RES-1];
      acc_z   = !tz[RES-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) it_valid_q[k+1] <= 1'b0;
      else if (en) it_valid_q[k+1] <= it_valid_q[k];
    end

    // Advance: take the trial bit where the residual stays non-negative.
    always_ff @(posedge clk_i) begin
      if (en) begin
        it_rx_q[k+1]   <= acc_x ? tx : it_rx_q[k];
        it_rz_q[k+1]   <= acc_z ? tz : it_rz_q[k];
        it_px_q[k+1]   <= acc_x ? it_px_q[k] + (s2_w <<< (B + 1)) : it_px_q[k];
        it_pz_q[k+1]   <= acc_z ? it_pz_q[k] + (s2_w <<< (B + 1)) : it_pz_q[k];
        it_qx_q[k+1]   <= it_qx_q[k] | (L'(acc_x) << B);
        it_qz_q[k+1]   <= it_qz_q[k] | (L'(acc_z) << B);
        it_s2_q[k+1]   <= it_s2_q[k];
        it_sx_q[k+1]   <= it_sx_q[k];
        it_sz_q[k+1]   <= it_sz_q[k];
        it_h_q[k+1]    <= it_h_q[k];
        it_feat_q[k+1] <= it_feat_q[k];
      end
    end
  end

  // Output register
  logic signed [cspu_pkg::OUT_BITS-1:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic signed [cspu_pkg::OUT_BITS-1:0] qx_w, qz_w, h_w;
  cspu_pkg::feature_e feat_q;

  always_comb begin
    qx_w = cspu_pkg::OUT_BITS'(it_qx_q[L]);
    qz_w = cspu_pkg::OUT_BITS'(it_qz_q[L]);
    h_w  = cspu_pkg::OUT_BITS'(it_h_q[L]);
    px_d = '0;
    pz_d = '0;
    py_d = -h_w;
    case (it_feat_q[L])
      cspu_pkg::FEAT_APEX: py_d = h_w;
      cspu_pkg::FEAT_RIM: begin
        px_d = it_sx_q[L] ? -qx_w : qx_w;
        pz_d = it_sz_q[L] ? -qz_w : qz_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= it_valid_q[L];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;
      feat_q <= it_feat_q[L];
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign point_z_o   = pz_q;
  assign feature_o   = feat_q;

  `CSPU_ASSERT(a_apex_axis, out_valid_q && (feat_q == cspu_pkg::FEAT_APEX) |-> (px_q == '0) && (pz_q == '0) && !py_q[cspu_pkg::OUT_BITS-1], "apex result off axis")
  `CSPU_ASSERT(a_centre_axis, out_valid_q && (feat_q == cspu_pkg::FEAT_CENTRE) |-> (px_q == '0) && (pz_q == '0), "centre result off axis")
  `CSPU_ASSERT(a_stall_cause, in_stall_o |-> out_valid_q && out_stall_i, "stall without held result")
  `CSPU_ASSERT_NEXT(a_drain, out_valid_q && !out_stall_i && !it_valid_q[L], !out_valid_q, "result repeated")

endmodule

>>> tb/sv/cone_support_point_unit_tb.sv
// ----------------------------------------------------------------------------
// cone_support_point_unit_tb
// Drives search directions into the cone support point unit under several
// radius/half-height settings and compares every support point, field by
// field, with an in-bench integer predictor of the apex test and rim rounding.
// ----------------------------------------------------------------------------
module cone_support_point_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 21;
  localparam int WATCHDOG  = 20000;

  typedef struct packed {
    logic signed [cspu_pkg::OUT_BITS-1:0] px;
    logic signed [cspu_pkg::OUT_BITS-1:0] py;
    logic signed [cspu_pkg::OUT_BITS-1:0] pz;
    cspu_pkg::feature_e                   feat;
  } support_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [cspu_pkg::CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [cspu_pkg::LEN_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [cspu_pkg::DIR_BITS-1:0] direction_x_i = '0;
  logic signed [cspu_pkg::DIR_BITS-1:0] direction_y_i = '0;
  logic signed [cspu_pkg::DIR_BITS-1:0] direction_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [cspu_pkg::OUT_BITS-1:0] point_x_o, point_y_o, point_z_o;
  logic [1:0] feature_o;

  cone_support_point_unit u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [cspu_pkg::LEN_BITS-1:0] cone_radius = cspu_pkg::RADIUS_RESET;
  logic [cspu_pkg::LEN_BITS-1:0] cone_half_height = cspu_pkg::HALF_HEIGHT_RESET;
  support_t expected_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  // Largest q with (2q-1)^2 * s2 <= (2*r*mag)^2: round half away from zero.
  function automatic logic [cspu_pkg::LEN_BITS-1:0] rim_magnitude(logic [63:0] r,
                                                                  logic [63:0] mag,
                                                                  logic [63:0] s2);
    logic [127:0] bound;
    logic [127:0] trial;
    logic [63:0] q;
    logic [63:0] e;
    bound = (128'(2 * r * mag)) * (128'(2 * r * mag));
    q = 0;
    for (int b = cspu_pkg::LEN_BITS - 1; b >= 0; b--) begin
      e = 2 * (q | (64'd1 << b)) - 1;
      trial = 128'(e) * 128'(e) * 128'(s2);
      if (trial <= bound) q = q | (64'd1 << b);
    end
    return q[cspu_pkg::LEN_BITS-1:0];
  endfunction

  function automatic support_t cone_support(logic signed [cspu_pkg::DIR_BITS-1:0] dx,
                                            logic signed [cspu_pkg::DIR_BITS-1:0] dy,
                                            logic signed [cspu_pkg::DIR_BITS-1:0] dz);
    support_t p;
    logic [63:0] ax, ay, az, s2, t;
    logic [127:0] axis_sq, radial_sq;
    logic [cspu_pkg::LEN_BITS-1:0] mx, mz;
    ax = dx < 0 ? 64'(-64'(dx)) : 64'(dx);
    ay = dy < 0 ? 64'(-64'(dy)) : 64'(dy);
    az = dz < 0 ? 64'(-64'(dz)) : 64'(dz);
    s2 = ax * ax + az * az;
    t = 2 * 64'(cone_half_height) * ay;
    axis_sq = 128'(t) * 128'(t);
    radial_sq = 128'(64'(cone_radius) * 64'(cone_radius)) * 128'(s2);
    if (dy > 0 && axis_sq > radial_sq) begin
      p.px = '0;
      p.py = cspu_pkg::OUT_BITS'(cone_half_height);
      p.pz = '0;
      p.feat = cspu_pkg::FEAT_APEX;
    end else if (s2 != 0) begin
      mx = rim_magnitude(64'(cone_radius), ax, s2);
      mz = rim_magnitude(64'(cone_radius), az, s2);
      p.px = dx < 0 ? -cspu_pkg::OUT_BITS'(mx) : cspu_pkg::OUT_BITS'(mx);
      p.py = -cspu_pkg::OUT_BITS'(cone_half_height);
      p.pz = dz < 0 ? -cspu_pkg::OUT_BITS'(mz) : cspu_pkg::OUT_BITS'(mz);
      p.feat = cspu_pkg::FEAT_RIM;
    end else begin
      p.px = '0;
      p.py = -cspu_pkg::OUT_BITS'(cone_half_height);
      p.pz = '0;
      p.feat = cspu_pkg::FEAT_CENTRE;
    end
    return p;
  endfunction

  // Receiver stall, with an optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check results at the rising edge.
  always @(posedge clk_i) begin
    support_t exp_p;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d", point_x_o, point_y_o, point_z_o);
        errors++;
      end else begin
        exp_p = expected_points.pop_front();
        if (point_x_o !== exp_p.px) begin
          $error("point_x expected %0d actual %0d", exp_p.px, point_x_o); errors++;
        end
        if (point_y_o !== exp_p.py) begin
          $error("point_y expected %0d actual %0d", exp_p.py, point_y_o); errors++;
        end
        if (point_z_o !== exp_p.pz) begin
          $error("point_z expected %0d actual %0d", exp_p.pz, point_z_o); errors++;
        end
        if (feature_o !== exp_p.feat) begin
          $error("feature expected %0d actual %0d", exp_p.feat, feature_o); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("cone_support_point_unit_tb failed");
      $finish;
    end
  end

  // Leave valid high after acceptance; the next idle cycle or drain drops it.
  task automatic send_direction(logic signed [cspu_pkg::DIR_BITS-1:0] dx,
                                logic signed [cspu_pkg::DIR_BITS-1:0] dy,
                                logic signed [cspu_pkg::DIR_BITS-1:0] dz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    direction_x_i <= dx;
    direction_y_i <= dy;
    direction_z_i <= dz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_points.push_back(cone_support(dx, dy, dz));
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [cspu_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [cspu_pkg::LEN_BITS-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    if (idx == cspu_pkg::REG_RADIUS) cone_radius = val;
    else if (idx == cspu_pkg::REG_HALF_HEIGHT) cone_half_height = val;
  endtask

  task automatic set_cone(logic [cspu_pkg::LEN_BITS-1:0] r,
                          logic [cspu_pkg::LEN_BITS-1:0] h);
    drain();
    write_reg(cspu_pkg::REG_RADIUS, r);
    write_reg(cspu_pkg::REG_HALF_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [cspu_pkg::DIR_BITS-1:0] random_component();
    case ($urandom_range(5))
      0: return cspu_pkg::DIR_BITS'(-32768);
      1: return cspu_pkg::DIR_BITS'(32767);
      2: return cspu_pkg::DIR_BITS'(0);
      3: return cspu_pkg::DIR_BITS'($urandom_range(8)) - cspu_pkg::DIR_BITS'(4);
      default: return cspu_pkg::DIR_BITS'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    send_direction(0, 0, 0);
    send_direction(0, 1, 0);
    send_direction(0, -1, 0);
    send_direction(1, 0, 0);
    send_direction(0, 0, -1);
    send_direction(-32768, -32768, -32768);
    send_direction(32767, 32767, 32767);
    send_direction(-32768, 32767, 0);
    send_direction(3, 4, 4);
    send_direction(1, 1, 1);
    send_direction(1, 0, 1);
    send_direction(-1, 5, -1);
    send_direction(32767, 1, -32768);
    send_direction(0, 32767, 1);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_direction(random_component(), random_component(), random_component());
  endtask

  task automatic test_cone_shapes;
    set_cone(16'd0, 16'd0);
    test_directed();
    test_random(30);
    set_cone(16'hFFFF, 16'hFFFF);
    test_directed();
    test_random(30);
    set_cone(16'd0, 16'hFFFF);
    test_random(25);
    set_cone(16'hFFFF, 16'd1);
    test_random(25);
  endtask

  task automatic test_idle_mixes;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 29 : phase == 1 ? 48 : 0;
      recv_idle_pct = phase == 0 ? 48 : phase == 1 ? 29 : 0;
      set_cone(16'($urandom), 16'($urandom));
      test_random(100);
      set_cone(16'($urandom_range(1024)), 16'($urandom_range(1024)));
      test_random(100);
    end
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      test_random(60);
    join
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_cone_shapes();
    test_idle_mixes();
    test_backpressure();
    set_cone(cspu_pkg::RADIUS_RESET, cspu_pkg::HALF_HEIGHT_RESET);
    test_random(50);
    drain();
    if (errors == 0 && expected_points.size() == 0)
      $display("cone_support_point_unit_tb passed");
    else
      $display("cone_support_point_unit_tb failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/cspu_pkg.sv
src/cone_support_point_unit.sv
tb/sv/cone_support_point_unit_tb.sv
